// ===== hw/rtl/afcpt_pkg.sv =====
// Package for the ADC frame channel peak tracker: types, codes and constants.
package afcpt_pkg;

  localparam int EXT_W           = 24;   // sample and min width at the ports, extrema width inside
  localparam int MAX_W           = 23;   // width of the max fields
  localparam int WORD_W          = 32;
  localparam int LEFT_W          = 14;   // payload word counter
  localparam int CHAN_W          = 8;
  localparam int FBYTES_W        = 16;
  localparam int CFG_DATA_W      = 16;
  localparam int CFG_ADDR_W      = 1;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int OUT_DATA_W      = 120;  // 118 field bits padded to whole bytes

  localparam logic [WORD_W-1:0]     MARKER_WORD      = 32'hFFFF_FFFF;
  localparam logic [CHAN_W-1:0]     CHANNEL_ID_RST   = 8'd234;
  localparam logic [FBYTES_W-1:0]   MAX_FBYTES_RST   = 16'd1500;

  localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_ID   = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FBYTES   = 1'd1;

  localparam logic REQ_STREAM = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_SIZE    = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef logic signed [EXT_W-1:0] ext_t;

endpackage

// ===== hw/rtl/adc_frame_channel_peak_tracker_core.sv =====
// Top level: stream deframer with max/min peak tracking for the configured channel.
//
//  channel | dir | tdata (low bit up)                                  | tuser
//  s_*     | in  | data_word[31:0]                                     | req_type
//  m_*     | out | sample, first_max, second_max, first_min,           | kind
//          |     | second_min, 2 zero pad bits                         |
//  cfg_*   | in  | index 0 channel_id, index 1 max_frame_bytes         | -
//
// One word per cycle while s_tready is high: parse and compare-update run between
// the input handshake and the result register; m_tvalid rises in the next cycle.
// s_tready is high while the result register is empty or being drained.
// A stalled result holds; requests that make no result still flow past it
// only when the register can take a new one.
// rst (synchronous) returns the parser to marker hunt, zeroes the extrema and
// loads the register defaults.
module adc_frame_channel_peak_tracker_core
  import afcpt_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [WORD_W-1:0]       s_tdata,   // data_word[31:0]
  input  logic                    s_tuser,   // req_type
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [OUT_DATA_W-1:0]   m_tdata,   // sample[23:0], first_max[46:24],
                                             // second_max[69:47], first_min[93:70],
                                             // second_min[117:94], zero[119:118]
  output logic                    m_tuser,   // kind
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  logic [CHAN_W-1:0]   channel_id;
  logic [FBYTES_W-1:0] max_frame_bytes;

  phase_t              phase, phase_next;
  logic [LEFT_W-1:0]   payload_left, payload_left_next;
  ext_t                top_max, top_max_next;
  ext_t                next_max, next_max_next;
  ext_t                top_min, top_min_next;
  ext_t                next_min, next_min_next;

  logic                accept;
  logic                match;
  logic [LEFT_W-1:0]   left_dec;
  logic signed [SAMPLE_BITS-1:0] code;
  ext_t                sample_val;

  logic                res_valid;
  logic                res_kind;
  ext_t                res_sample;
  ext_t                res_top_max, res_next_max, res_top_min, res_next_min;

  logic                out_valid;
  logic                out_kind;
  ext_t                out_sample;
  logic [MAX_W-1:0]    out_first_max, out_second_max;
  ext_t                out_first_min, out_second_min;

  assign s_tready   = !out_valid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign code       = s_tdata[SAMPLE_BITS-1:0];
  assign sample_val = EXT_W'(code);
  assign match      = (s_tdata[WORD_W-1:WORD_W-CHAN_W] == channel_id);
  assign left_dec   = payload_left - LEFT_W'(1);

  // next state: parser and extrema
  always_comb begin
    phase_next        = phase;
    payload_left_next = payload_left;
    top_max_next      = top_max;
    next_max_next     = next_max;
    top_min_next      = top_min;
    next_min_next     = next_min;
    if (accept) begin
      if (s_tuser == REQ_REPORT) begin
        top_max_next  = '0;
        next_max_next = '0;
        top_min_next  = '0;
        next_min_next = '0;
      end else begin
        case (phase)
          PH_HUNT: begin
            if (s_tdata == MARKER_WORD) phase_next = PH_HEADER;
          end
          PH_HEADER: begin
            phase_next = s_tdata[WORD_W-1] ? PH_HUNT : PH_SIZE;
          end
          PH_SIZE: begin
            if (s_tdata > {{(WORD_W-FBYTES_W){1'b0}}, max_frame_bytes}) begin
              phase_next = PH_HUNT;
            end else begin
              payload_left_next = s_tdata[LEFT_W+1:2];
              phase_next = (s_tdata[LEFT_W+1:2] != '0) ? PH_PAYLOAD : PH_HUNT;
            end
          end
          PH_PAYLOAD: begin
            payload_left_next = left_dec;
            if (left_dec == '0) phase_next = PH_HUNT;
            if (match) begin
              if (sample_val > 0) begin
                if (sample_val > top_max) begin
                  next_max_next = top_max;
                  top_max_next  = sample_val;
                end else if (sample_val < top_max && sample_val > next_max) begin
                  next_max_next = sample_val;
                end
              end else if (sample_val < 0) begin
                if (sample_val < top_min) begin
                  next_min_next = top_min;
                  top_min_next  = sample_val;
                end else if (sample_val > top_min && sample_val < next_min) begin
                  next_min_next = sample_val;
                end
              end
            end
          end
          default: phase_next = PH_HUNT;
        endcase
      end
    end
  end

  // result: reports carry pre-clear values, samples the updated ones
  always_comb begin
    res_valid    = 1'b0;
    res_kind     = KIND_SAMPLE;
    res_sample   = sample_val;
    res_top_max  = top_max_next;
    res_next_max = next_max_next;
    res_top_min  = top_min_next;
    res_next_min = next_min_next;
    if (accept) begin
      if (s_tuser == REQ_REPORT) begin
        res_valid    = 1'b1;
        res_kind     = KIND_REPORT;
        res_sample   = '0;
        res_top_max  = top_max;
        res_next_max = next_max;
        res_top_min  = top_min;
        res_next_min = next_min;
      end else if (phase == PH_PAYLOAD && match) begin
        res_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_id      <= CHANNEL_ID_RST;
      max_frame_bytes <= MAX_FBYTES_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CHANNEL_ID: channel_id      <= cfg_data[CHAN_W-1:0];
        CFG_MAX_FBYTES: max_frame_bytes <= cfg_data[FBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      payload_left <= '0;
      top_max      <= '0;
      next_max     <= '0;
      top_min      <= '0;
      next_min     <= '0;
      out_valid    <= 1'b0;
    end else begin
      phase        <= phase_next;
      payload_left <= payload_left_next;
      top_max      <= top_max_next;
      next_max     <= next_max_next;
      top_min      <= top_min_next;
      next_min     <= next_min_next;
      if (s_tready) out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && res_valid) begin
      out_kind       <= res_kind;
      out_sample     <= res_sample;
      out_first_max  <= res_top_max[MAX_W-1:0];
      out_second_max <= res_next_max[MAX_W-1:0];
      out_first_min  <= res_top_min;
      out_second_min <= res_next_min;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = {2'b00, out_second_min, out_first_min, out_second_max,
                     out_first_max, out_sample};

endmodule
